// File: hw/rtl/gfa_pkg.sv
// shared widths, register indexes, queue entry type and helpers
// for the gated frequency averager; no dependencies
package gfa_pkg;

  localparam int SNAP_W        = 48;
  localparam int SUM_W         = 53;
  localparam int GATE_W        = 4;
  localparam int SAMP_W        = 6;
  localparam int MAX_SAMPLES   = 32;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int BITS_PER_STEP = 2;
  localparam int DIV_W         = ((SUM_W + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
  localparam int DIV_STEPS     = DIV_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam logic REG_GATE    = 1'b0;
  localparam logic REG_SAMPLES = 1'b1;

  localparam logic [GATE_W-1:0] GATE_RESET    = GATE_W'(2);
  localparam logic [SAMP_W-1:0] SAMPLES_RESET = SAMP_W'(2);

  typedef struct packed {
    logic [GATE_W-1:0] gate;
    logic [SAMP_W-1:0] samples;
    logic              clear;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [SAMP_W-1:0] samples;
    logic [GATE_W-1:0] gate;
  } job_t;

  function automatic logic [SAMP_W-1:0] eff_samples(input logic [SAMP_W-1:0] n);
    logic [SAMP_W-1:0] r;
    r = n;
    if (n == '0) r = SAMP_W'(1);
    if (n > SAMP_W'(MAX_SAMPLES)) r = SAMP_W'(MAX_SAMPLES);
    return r;
  endfunction

  function automatic logic [GATE_W-1:0] eff_gate(input logic [GATE_W-1:0] g);
    return (g == '0) ? GATE_W'(1) : g;
  endfunction

endpackage

// File: hw/rtl/gfa_front.sv
// front end: takes gate-end transactions, forms the count difference,
// accumulates the sum and queues a job per completed average; uses gfa_pkg
module gfa_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gfa_pkg::SNAP_W-1:0]  counter_snapshot,
  input  gfa_pkg::cfg_t               cfg,
  input  logic                        q_full,
  output logic                        q_push,
  output gfa_pkg::job_t               q_job
);
  import gfa_pkg::*;

  logic [SNAP_W-1:0] previous_snapshot;
  logic [SAMP_W-1:0] gates_collected;
  logic [SUM_W-1:0]  count_sum;

  logic [SNAP_W-1:0] diff;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_next;
  logic [SAMP_W-1:0] gates_next;
  logic              done;
  logic              accept;

  assign in_stall   = q_full;
  assign accept     = in_valid && !in_stall;
  assign diff       = counter_snapshot - previous_snapshot;
  assign sum_wide   = {1'b0, count_sum} + (SUM_W + 1)'(diff);
  assign sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign gates_next = gates_collected + SAMP_W'(1);
  assign done       = gates_next >= cfg.samples;

  assign q_push        = accept && done;
  assign q_job.sum     = sum_next;
  assign q_job.samples = cfg.samples;
  assign q_job.gate    = cfg.gate;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_snapshot <= '0;
      gates_collected   <= '0;
      count_sum         <= '0;
    end else if (cfg.clear) begin
      gates_collected <= '0;
      count_sum       <= '0;
    end else if (accept) begin
      previous_snapshot <= counter_snapshot;
      if (done) begin
        gates_collected <= '0;
        count_sum       <= '0;
      end else begin
        gates_collected <= gates_next;
        count_sum       <= sum_next;
      end
    end
  end

endmodule

// File: hw/rtl/gfa_queue.sv
// short job queue between the front end and the divider back end
// uses gfa_pkg
module gfa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gfa_pkg::job_t push_job,
  input  logic          pop,
  output gfa_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import gfa_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// File: hw/rtl/gfa_back.sv
// back end: shared radix-4 restoring divider giving sum/samples then
// mean/gate, with a registered result output; uses gfa_pkg
module gfa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  gfa_pkg::job_t               q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gfa_pkg::SNAP_W-1:0]  mean_count,
  output logic [gfa_pkg::SNAP_W-1:0]  frequency_hz
);
  import gfa_pkg::*;

  typedef enum logic [3:0] {
    IDLE     = 4'b0001,
    DIV_MEAN = 4'b0010,
    DIV_FREQ = 4'b0100,
    OUTPUT   = 4'b1000
  } state_t;

  state_t            state;
  logic [DIV_W-1:0]  quo;
  logic [SAMP_W-1:0] rem;
  logic [SAMP_W-1:0] divisor;
  logic [GATE_W-1:0] gate;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  mean;

  logic [DIV_W-1:0]  step_quo;
  logic [SAMP_W-1:0] step_rem;
  logic [SAMP_W:0]   trial;
  logic              last_step;
  logic              out_free;

  always_comb begin
    step_quo = quo;
    step_rem = rem;
    trial    = '0;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      trial = {step_rem, step_quo[DIV_W-1]};
      if (trial >= {1'b0, divisor}) begin
        step_rem = SAMP_W'(trial - {1'b0, divisor});
        step_quo = {step_quo[DIV_W-2:0], 1'b1};
      end else begin
        step_rem = trial[SAMP_W-1:0];
        step_quo = {step_quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign last_step = (step == STEP_W'(DIV_STEPS - 1));
  assign q_pop     = (state == IDLE) && !q_empty;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == OUTPUT) && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (!q_empty) state <= DIV_MEAN;
        end
        DIV_MEAN: begin
          if (last_step) state <= DIV_FREQ;
        end
        DIV_FREQ: begin
          if (last_step) state <= OUTPUT;
        end
        OUTPUT: begin
          if (out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      IDLE: begin
        quo     <= DIV_W'(q_head.sum);
        rem     <= '0;
        divisor <= q_head.samples;
        gate    <= q_head.gate;
        step    <= '0;
      end
      DIV_MEAN: begin
        if (last_step) begin
          mean    <= step_quo[SUM_W-1:0];
          quo     <= DIV_W'(step_quo[SUM_W-1:0]);
          rem     <= '0;
          divisor <= SAMP_W'(gate);
          step    <= '0;
        end else begin
          quo  <= step_quo;
          rem  <= step_rem;
          step <= step + STEP_W'(1);
        end
      end
      DIV_FREQ: begin
        quo  <= step_quo;
        rem  <= step_rem;
        step <= step + STEP_W'(1);
      end
      OUTPUT: begin
        if (out_free) begin
          mean_count   <= mean[SNAP_W-1:0];
          frequency_hz <= quo[SNAP_W-1:0];
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/gated_frequency_averager.sv
// gated frequency averager top level: register port, front end, job queue
// and divider back end; uses gfa_pkg, gfa_front, gfa_queue, gfa_back
// the shared divider runs a pass for the mean, then for the frequency
// throughput: one input transaction per cycle while the queue has room;
// the two-bit-per-cycle divider takes the next job once a result is
// loaded into the output register
// reset (synchronous): sum, gate count and previous snapshot cleared,
// queue emptied, registers back to gate 2 s and 2 samples
module gated_frequency_averager (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gfa_pkg::SNAP_W-1:0]  counter_snapshot,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gfa_pkg::SNAP_W-1:0]  mean_count,
  output logic [gfa_pkg::SNAP_W-1:0]  frequency_hz,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gfa_pkg::ADDR_W-1:0]  paddr,
  input  logic [gfa_pkg::DATA_W-1:0]  pwdata,
  output logic [gfa_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import gfa_pkg::*;

  logic [GATE_W-1:0] gate_seconds;
  logic [SAMP_W-1:0] samples_per_result;
  logic              wr;
  logic              reg_idx;
  cfg_t              cfg;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  job_t              q_job;
  job_t              q_head;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_seconds       <= GATE_RESET;
      samples_per_result <= SAMPLES_RESET;
    end else if (wr) begin
      unique case (reg_idx)
        REG_GATE:    gate_seconds       <= pwdata[GATE_W-1:0];
        REG_SAMPLES: samples_per_result <= pwdata[SAMP_W-1:0];
        default:     gate_seconds       <= gate_seconds;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GATE:    prdata = DATA_W'(gate_seconds);
      REG_SAMPLES: prdata = DATA_W'(samples_per_result);
      default:     prdata = '0;
    endcase
  end

  assign cfg.gate    = eff_gate(gate_seconds);
  assign cfg.samples = eff_samples(samples_per_result);
  assign cfg.clear   = wr && (reg_idx == REG_SAMPLES);

  gfa_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .counter_snapshot (counter_snapshot),
    .cfg              (cfg),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (q_job)
  );

  gfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  gfa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mean_count   (mean_count),
    .frequency_hz (frequency_hz)
  );

endmodule

// File: hw/rtl/gfa_checker.sv
// port-level checks for the gated frequency averager, bound to the top
// level; uses gfa_pkg
module gfa_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [gfa_pkg::SNAP_W-1:0]  mean_count,
  input  logic [gfa_pkg::SNAP_W-1:0]  frequency_hz,
  input  logic                        pready
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_count) && $stable(frequency_hz))
    else $error("stalled result changed");

  // frequency never exceeds the mean count
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frequency_hz <= mean_count)
    else $error("frequency above mean count");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind gated_frequency_averager gfa_checker u_gfa_checker (.*);
